// File: rtl/pocc_pkg.sv
// ----------------------------------------------------------------------------
// pocc_pkg
// Shared types and constants for the point/obstacle collision checker.
// ----------------------------------------------------------------------------
package pocc_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;

    localparam int MAX_CIRCLES_DEF = 16;
    localparam int MAX_RECTS_DEF   = 16;

    localparam logic [SIZE_W-1:0] MARGIN_RESET = 15'd51;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_CIRCLE = 2'd1,
        KIND_RECT   = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0]         r;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } circ_t;

    typedef struct packed {
        logic [SIZE_W-1:0]         h;
        logic [SIZE_W-1:0]         w;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } rect_t;

    localparam int CIRC_W = $bits(circ_t);
    localparam int RECT_W = $bits(rect_t);

endpackage

// File: rtl/pocc_ram.sv
// ----------------------------------------------------------------------------
// pocc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pocc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/point_obstacle_collision_check.sv
// ----------------------------------------------------------------------------
// point_obstacle_collision_check
// Circle and rectangle obstacle tables with a margin-inflated point test.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata / data                              | tuser
//  s_axis   | in  | x_pos, y_pos, size_a, size_b (64 bit)     | kind
//  m_axis   | out | hit (8 bit)                               | status
//  cfg      | in  | margin (15 bit), always ready             | -
//
//  Clear and append words pass IDLE and DONE; queries step through CRD, CSX,
//  CSY, CSR, CCMP per circle tested and RRD, RCX (RCY if x is in span) per
//  rectangle; one squarer, one subtract/compare unit, shared by every entry.
//  One word in flight; s_axis_tready is low until its result is registered.
//  A result waiting on m_axis does not block the next accept.
//  rst_n (asynchronous, active low) empties both tables and restores margin.
// ----------------------------------------------------------------------------
module point_obstacle_collision_check #(
    parameter int MAX_CIRCLES = pocc_pkg::MAX_CIRCLES_DEF,
    parameter int MAX_RECTS   = pocc_pkg::MAX_RECTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,  // x_pos, y_pos, size_a, size_b
    input  logic [1:0]                s_axis_tuser,  // kind
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // hit
    output logic                      m_axis_tuser,  // status
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [pocc_pkg::SIZE_W-1:0] cfg_data
);

    import pocc_pkg::*;

    localparam int C_IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int R_IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int C_CNT_W = $clog2(MAX_CIRCLES + 1);
    localparam int R_CNT_W = $clog2(MAX_RECTS + 1);
    localparam int IDX_W   = (C_IDX_W > R_IDX_W) ? C_IDX_W : R_IDX_W;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_CRD  = 10'b0000000010,
        ST_CSX  = 10'b0000000100,
        ST_CSY  = 10'b0000001000,
        ST_CSR  = 10'b0000010000,
        ST_CCMP = 10'b0000100000,
        ST_RRD  = 10'b0001000000,
        ST_RCX  = 10'b0010000000,
        ST_RCY  = 10'b0100000000,
        ST_DONE = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [C_CNT_W-1:0]   circ_cnt_reg, circ_cnt_next;
    logic [R_CNT_W-1:0]   rect_cnt_reg, rect_cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SIZE_W-1:0]    margin_reg;
    logic                 hit_reg, hit_next;
    logic                 status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_hit_reg;
    logic                 m_status_reg;
    logic                 out_load;

    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic [31:0]               sq_reg, sq_next;
    logic [32:0]               acc_reg, acc_next;

    kind_t                in_kind;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic [SIZE_W-1:0]    in_a, in_b;
    logic                 in_accept;

    logic                 circ_we, rect_we;
    circ_t                circ_wdata, circ_rd;
    rect_t                rect_wdata, rect_rd;
    logic [C_IDX_W-1:0]   circ_waddr;
    logic [R_IDX_W-1:0]   rect_waddr;

    logic signed [COORD_W-1:0] sub_a, sub_b;
    logic signed [COORD_W:0]   diff;
    logic [COORD_W-1:0]        diff_abs;
    logic [COORD_W-1:0]        sq_in;
    logic [31:0]               sq_out;
    logic [SIZE_W-1:0]         span;
    logic [COORD_W-1:0]        span_m;
    logic signed [COORD_W+1:0] diff_ext;
    logic                      in_span;
    logic                      circ_last;
    logic                      rect_last;

    assign in_kind   = kind_t'(s_axis_tuser);
    assign in_x      = s_axis_tdata[15:0];
    assign in_y      = s_axis_tdata[31:16];
    assign in_a      = s_axis_tdata[46:32];
    assign in_b      = s_axis_tdata[61:47];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_hit_reg};
    assign m_axis_tuser  = m_status_reg;

    assign circ_we    = in_accept && (in_kind == KIND_CIRCLE)
                        && (circ_cnt_reg != C_CNT_W'(MAX_CIRCLES));
    assign rect_we    = in_accept && (in_kind == KIND_RECT)
                        && (rect_cnt_reg != R_CNT_W'(MAX_RECTS));
    assign circ_waddr = C_IDX_W'(circ_cnt_reg);
    assign rect_waddr = R_IDX_W'(rect_cnt_reg);
    assign circ_wdata = '{r: in_a, y: in_y, x: in_x};
    assign rect_wdata = '{h: in_b, w: in_a, y: in_y, x: in_x};

    pocc_ram #(
        .WIDTH  (CIRC_W),
        .DEPTH  (MAX_CIRCLES),
        .ADDR_W (C_IDX_W)
    ) u_circ_ram (
        .clk   (clk),
        .we    (circ_we),
        .waddr (circ_waddr),
        .wdata (circ_wdata),
        .raddr (C_IDX_W'(idx_reg)),
        .rdata (circ_rd)
    );

    pocc_ram #(
        .WIDTH  (RECT_W),
        .DEPTH  (MAX_RECTS),
        .ADDR_W (R_IDX_W)
    ) u_rect_ram (
        .clk   (clk),
        .we    (rect_we),
        .waddr (rect_waddr),
        .wdata (rect_wdata),
        .raddr (R_IDX_W'(idx_reg)),
        .rdata (rect_rd)
    );

    // shared subtract / abs / squarer / range compare
    always_comb
    begin
        sub_a = px_reg;
        sub_b = circ_rd.x;
        span  = rect_rd.w;
        case (state_reg)
            ST_CSX:
            begin
                sub_a = px_reg;
                sub_b = circ_rd.x;
            end
            ST_CSY:
            begin
                sub_a = py_reg;
                sub_b = circ_rd.y;
            end
            ST_RCX:
            begin
                sub_a = px_reg;
                sub_b = rect_rd.x;
                span  = rect_rd.w;
            end
            ST_RCY:
            begin
                sub_a = py_reg;
                sub_b = rect_rd.y;
                span  = rect_rd.h;
            end
            default:
            begin
                sub_a = px_reg;
                sub_b = circ_rd.x;
                span  = rect_rd.w;
            end
        endcase
    end

    assign diff     = {sub_a[COORD_W-1], sub_a} - {sub_b[COORD_W-1], sub_b};
    assign diff_abs = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
    assign span_m   = {1'b0, span} + {1'b0, margin_reg};
    assign diff_ext = {diff[COORD_W], diff};
    assign in_span  = ((diff_ext + $signed({3'b0, margin_reg})) >= 0)
                      && (diff_ext <= $signed({2'b0, span_m}));

    assign sq_in  = (state_reg == ST_CSR) ? ({1'b0, circ_rd.r} + {1'b0, margin_reg})
                                          : diff_abs;
    assign sq_out = sq_in * sq_in;

    assign circ_last = (C_CNT_W'(idx_reg) + C_CNT_W'(1)) == circ_cnt_reg;
    assign rect_last = (R_CNT_W'(idx_reg) + R_CNT_W'(1)) == rect_cnt_reg;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next    = state_reg;
        circ_cnt_next = circ_cnt_reg;
        rect_cnt_next = rect_cnt_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        sq_next       = sq_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    hit_next    = 1'b0;
                    status_next = 1'b0;
                    idx_next    = '0;
                    state_next  = ST_DONE;
                    case (in_kind)
                        KIND_CLEAR:
                        begin
                            circ_cnt_next = '0;
                            rect_cnt_next = '0;
                        end
                        KIND_CIRCLE:
                        begin
                            if (circ_we)
                            begin
                                circ_cnt_next = circ_cnt_reg + C_CNT_W'(1);
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        KIND_RECT:
                        begin
                            if (rect_we)
                            begin
                                rect_cnt_next = rect_cnt_reg + R_CNT_W'(1);
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (circ_cnt_reg != '0)
                            begin
                                state_next = ST_CRD;
                            end
                            else if (rect_cnt_reg != '0)
                            begin
                                state_next = ST_RRD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CRD:
            begin
                state_next = ST_CSX;
            end
            ST_CSX:
            begin
                sq_next    = sq_out;
                state_next = ST_CSY;
            end
            ST_CSY:
            begin
                acc_next   = {1'b0, sq_reg};
                sq_next    = sq_out;
                state_next = ST_CSR;
            end
            ST_CSR:
            begin
                acc_next   = acc_reg + {1'b0, sq_reg};
                sq_next    = sq_out;
                state_next = ST_CCMP;
            end
            ST_CCMP:
            begin
                if (acc_reg < {1'b0, sq_reg})
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!circ_last)
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_CRD;
                end
                else if (rect_cnt_reg != '0)
                begin
                    idx_next   = '0;
                    state_next = ST_RRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RRD:
            begin
                state_next = ST_RCX;
            end
            ST_RCX:
            begin
                if (in_span)
                begin
                    state_next = ST_RCY;
                end
                else if (!rect_last)
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_RRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RCY:
            begin
                if (in_span)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!rect_last)
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_RRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            circ_cnt_reg <= '0;
            rect_cnt_reg <= '0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            status_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            margin_reg   <= MARGIN_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            circ_cnt_reg <= circ_cnt_next;
            rect_cnt_reg <= rect_cnt_next;
            idx_reg      <= idx_next;
            hit_reg      <= hit_next;
            status_reg   <= status_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                margin_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
        if (in_accept)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (out_load)
        begin
            m_hit_reg    <= hit_reg;
            m_status_reg <= status_reg;
        end
    end

endmodule

// File: verif/point_obstacle_collision_check_tb.sv
// ----------------------------------------------------------------------------
// point_obstacle_collision_check_tb
// Self-checking bench for the point/obstacle collision checker. Directed
// words probe the circle and rectangle bounds, the margin extremes and full
// tables; random scenes then build obstacle sets and aim queries at them.
// Every result word is compared with a cycle-free model of both tables.
// ----------------------------------------------------------------------------
module point_obstacle_collision_check_tb;

    import pocc_pkg::*;

    localparam int WORD_TARGET    = 1350;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 150;

    typedef struct packed {
        logic hit;
        logic status;
    } result_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata  = '0;  // x_pos, y_pos, size_a, size_b
    logic [1:0]          s_axis_tuser  = '0;  // kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;        // hit
    logic                m_axis_tuser;        // status
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_data      = '0;

    circ_t               circ_tab [MAX_CIRCLES_DEF];
    rect_t               rect_tab [MAX_RECTS_DEF];
    int unsigned         circ_n        = 0;
    int unsigned         rect_n        = 0;
    logic [SIZE_W-1:0]   margin_q      = MARGIN_RESET;

    result_t             pending_results [$];
    int unsigned         error_count   = 0;
    int unsigned         words_sent    = 0;
    int unsigned         results_seen  = 0;
    int unsigned         idle_cycles   = 0;
    int unsigned         stall_left    = 0;
    bit                  tx_idle       = 1'b1;
    bit                  rx_idle       = 1'b1;

    point_obstacle_collision_check DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit point_collides(logic signed [COORD_W-1:0] px,
                                          logic signed [COORD_W-1:0] py);
        longint m;
        longint dx;
        longint dy;
        longint reach;
        m = longint'(margin_q);
        for (int unsigned i = 0; i < circ_n; i++)
        begin
            dx    = longint'(px) - longint'(circ_tab[i].x);
            dy    = longint'(py) - longint'(circ_tab[i].y);
            reach = longint'(circ_tab[i].r) + m;
            if (dx * dx + dy * dy < reach * reach)
                return 1'b1;
        end
        for (int unsigned i = 0; i < rect_n; i++)
        begin
            dx = longint'(px) - longint'(rect_tab[i].x);
            dy = longint'(py) - longint'(rect_tab[i].y);
            if (dx >= -m && dx <= longint'(rect_tab[i].w) + m &&
                dy >= -m && dy <= longint'(rect_tab[i].h) + m)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t track_obstacles(kind_t k,
                                                logic signed [COORD_W-1:0] x,
                                                logic signed [COORD_W-1:0] y,
                                                logic [SIZE_W-1:0] a,
                                                logic [SIZE_W-1:0] b);
        result_t res;
        res = '0;
        case (k)
            KIND_CLEAR:
            begin
                circ_n = 0;
                rect_n = 0;
            end
            KIND_CIRCLE:
            begin
                if (circ_n >= MAX_CIRCLES_DEF)
                    res.status = 1'b1;
                else
                begin
                    circ_tab[circ_n].x = x;
                    circ_tab[circ_n].y = y;
                    circ_tab[circ_n].r = a;
                    circ_n++;
                end
            end
            KIND_RECT:
            begin
                if (rect_n >= MAX_RECTS_DEF)
                    res.status = 1'b1;
                else
                begin
                    rect_tab[rect_n].x = x;
                    rect_tab[rect_n].y = y;
                    rect_tab[rect_n].w = a;
                    rect_tab[rect_n].h = b;
                    rect_n++;
                end
            end
            default:
                res.hit = point_collides(x, y);
        endcase
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        return SIZE_W'($urandom);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!tx_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int unsigned stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return rand_size();
        if (r < 3)
            return SIZE_W'($urandom_range(0, 64));
        return SIZE_W'($urandom_range(0, 1024));
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 7) == 0)
            return rand_coord();
        return clamp_coord(longint'($urandom_range(0, 8192)) - 4096);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_margin();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return '0;
        if (r < 4)
            return 15'h7FFF;
        if (r < 6)
            return rand_size();
        return SIZE_W'($urandom_range(0, 256));
    endfunction

    function automatic int unsigned pick_count();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(15, 18);
        return $urandom_range(0, 8);
    endfunction

    task automatic flag_mismatch(string msg);
        $display("MISMATCH at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic send_word(kind_t k,
                             logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y,
                             logic [SIZE_W-1:0] a,
                             logic [SIZE_W-1:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {2'b00, b, a, y, x};
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(track_obstacles(k, x, y, a, b));
        words_sent++;
    endtask

    task automatic set_margin(logic [SIZE_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        margin_q = v;
    endtask

    task automatic aim_query(output logic signed [COORD_W-1:0] qx,
                             output logic signed [COORD_W-1:0] qy);
        longint m;
        longint lo_x;
        longint hi_x;
        longint lo_y;
        longint hi_y;
        longint reach;
        int unsigned i;
        int unsigned sel;
        bit aimed;
        m     = longint'(margin_q);
        sel   = $urandom_range(0, 9);
        aimed = 1'b1;
        if (sel < 4 && circ_n != 0)
        begin
            i     = $urandom_range(0, circ_n - 1);
            reach = longint'(circ_tab[i].r) + m;
            lo_x  = longint'(circ_tab[i].x) - reach - 4;
            hi_x  = longint'(circ_tab[i].x) + reach + 4;
            lo_y  = longint'(circ_tab[i].y) - reach - 4;
            hi_y  = longint'(circ_tab[i].y) + reach + 4;
        end
        else if (sel < 8 && rect_n != 0)
        begin
            i    = $urandom_range(0, rect_n - 1);
            lo_x = longint'(rect_tab[i].x) - m - 2;
            hi_x = longint'(rect_tab[i].x) + longint'(rect_tab[i].w) + m + 2;
            lo_y = longint'(rect_tab[i].y) - m - 2;
            hi_y = longint'(rect_tab[i].y) + longint'(rect_tab[i].h) + m + 2;
        end
        else
            aimed = 1'b0;
        if (!aimed)
        begin
            qx = rand_coord();
            qy = rand_coord();
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            // sit on or just beside an edge of the grown box
            case ($urandom_range(0, 3))
                0: qx = clamp_coord(lo_x + 1);
                1: qx = clamp_coord(lo_x + 2);
                2: qx = clamp_coord(hi_x - 2);
                default: qx = clamp_coord(hi_x - 1);
            endcase
            qy = clamp_coord(lo_y + longint'($urandom_range(0, hi_y - lo_y)));
        end
        else
        begin
            qx = clamp_coord(lo_x + longint'($urandom_range(0, hi_x - lo_x)));
            qy = clamp_coord(lo_y + longint'($urandom_range(0, hi_y - lo_y)));
        end
    endtask

    task automatic test_empty_tables();
        send_word(KIND_QUERY, -32768, 32767, 15'h7FFF, 15'h7FFF);
        send_word(KIND_CLEAR, 32767, -32768, 15'h7FFF, 15'h7FFF);
        send_word(KIND_QUERY, 0, 0, 0, 0);
    endtask

    task automatic test_circle_bounds();
        send_word(KIND_CIRCLE, 0, 0, 15'd256, 15'h7FFF);
        send_word(KIND_QUERY, 307, 0, 15'h7FFF, 0);
        send_word(KIND_QUERY, 306, 0, 0, 15'h7FFF);
        send_word(KIND_QUERY, -217, 217, 0, 0);
        send_word(KIND_QUERY, 218, -217, 0, 0);
    endtask

    task automatic test_rect_bounds();
        send_word(KIND_CLEAR, 0, 0, 0, 0);
        send_word(KIND_RECT, 1000, -2000, 15'd512, 15'd256);
        send_word(KIND_QUERY, 949, -2051, 0, 0);
        send_word(KIND_QUERY, 948, -2051, 0, 0);
        send_word(KIND_QUERY, 1563, -1693, 0, 0);
        send_word(KIND_QUERY, 1563, -1692, 0, 0);
        send_word(KIND_RECT, -32768, -32768, 0, 0);
        send_word(KIND_QUERY, 32767, 32767, 0, 0);
        send_word(KIND_QUERY, -32768, -32768, 0, 0);
    endtask

    task automatic test_margin_extremes();
        set_margin('0);
        send_word(KIND_CLEAR, 0, 0, 0, 0);
        send_word(KIND_CIRCLE, 100, 100, 0, 15'h7FFF);
        send_word(KIND_QUERY, 100, 100, 0, 0);
        send_word(KIND_RECT, -5, -5, 0, 0);
        send_word(KIND_QUERY, -5, -5, 0, 0);
        send_word(KIND_QUERY, -4, -5, 0, 0);
        set_margin(15'h7FFF);
        send_word(KIND_CLEAR, 0, 0, 0, 0);
        send_word(KIND_CIRCLE, 32767, 32767, 15'h7FFF, 0);
        send_word(KIND_QUERY, -32768, -32768, 0, 0);
        send_word(KIND_QUERY, -32767, 32767, 0, 0);
        send_word(KIND_QUERY, -32766, 32767, 0, 0);
        set_margin(MARGIN_RESET);
    endtask

    task automatic test_full_tables();
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        send_word(KIND_CLEAR, rand_coord(), rand_coord(), rand_size(), rand_size());
        repeat (MAX_CIRCLES_DEF + 2)
            send_word(KIND_CIRCLE, pick_coord(), pick_coord(), pick_size(), rand_size());
        repeat (MAX_RECTS_DEF + 2)
            send_word(KIND_RECT, pick_coord(), pick_coord(), pick_size(), pick_size());
        repeat (12)
        begin
            aim_query(qx, qy);
            send_word(KIND_QUERY, qx, qy, rand_size(), rand_size());
        end
    endtask

    task automatic test_random_scenes();
        int unsigned n_circ;
        int unsigned n_rect;
        int unsigned n_query;
        int unsigned pick;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 2) == 0)
                set_margin(pick_margin());
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            send_word(KIND_CLEAR, rand_coord(), rand_coord(), rand_size(), rand_size());
            n_circ  = pick_count();
            n_rect  = pick_count();
            n_query = $urandom_range(4, 24);
            while (n_circ + n_rect + n_query != 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_word(kind_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                              rand_size(), rand_size());
                else if (pick < 7 && n_circ != 0)
                begin
                    send_word(KIND_CIRCLE, pick_coord(), pick_coord(), pick_size(),
                              rand_size());
                    n_circ--;
                end
                else if (pick < 13 && n_rect != 0)
                begin
                    send_word(KIND_RECT, pick_coord(), pick_coord(), pick_size(),
                              pick_size());
                    n_rect--;
                end
                else if (n_query != 0)
                begin
                    aim_query(qx, qy);
                    send_word(KIND_QUERY, qx, qy, rand_size(), rand_size());
                    n_query--;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (rx_idle && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_len() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result word with nothing pending");
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== {7'b0, want.hit})
                    flag_mismatch($sformatf("hit word %02h, want %0d",
                                            m_axis_tdata, want.hit));
                if (m_axis_tuser !== want.status)
                    flag_mismatch($sformatf("status %b, want %0d",
                                            m_axis_tuser, want.status));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_tables();
        test_circle_bounds();
        test_rect_bounds();
        test_margin_extremes();
        test_full_tables();
        test_random_scenes();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
